[rtl/yjt_pkg.sv]
package yjt_pkg;

   localparam int ITER = 24;
   localparam int FRAC_W = 48;
   localparam int LN_W = 36;
   localparam int P_W = 44;
   localparam int RED_W = 38;
   localparam int EXP_Q_W = 6;
   localparam int DIV_Q_W = 33;
   localparam int REM_W = 57;

   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
   localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
   localparam logic [23:0] LAMBDA_TWO = 24'h02_0000;
   localparam logic [24:0] LAMBDA_TWO_X = 25'h002_0000;
   localparam logic [P_W-1:0] EXP_LIMIT = 44'h014_0000_0000;
   localparam logic [P_W-1:0] ZERO_LIMIT = 44'd62 * {12'd0, LN2_Q32};
   localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_MIN = 32'h8000_0000;

   typedef struct packed {
      logic        negative;
      logic        logpath;
      logic        ovf;
      logic        l_neg;
      logic [23:0] lmag;
   } side_type;

   typedef struct packed {
      side_type    side;
      logic [19:0] logmag;
      logic        sat;
   } path_type;

endpackage

[rtl/yjt_log.sv]
module yjt_log
   import yjt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic signed [31:0]  sample,
   input  logic signed [23:0]  power,
   input  logic signed [31:0]  shift,
   output logic                out_valid,
   output logic [LN_W-1:0]     ln,
   output side_type            side
);

   logic [32:0] sum_w;
   logic [31:0] t_in;
   logic        ovf_in;
   logic        a_valid_ff;
   logic [31:0] a_t_ff;
   logic        a_ovf_ff;
   logic [23:0] a_power_ff;

   logic        neg_w;
   logic [31:0] tmag_w;
   logic [31:0] b_in;
   logic [24:0] l_w;
   side_type    side_in;
   logic        b_valid_ff;
   logic [31:0] b_b_ff;
   side_type    b_side_ff;

   logic [4:0]  msb_w;
   logic [31:0] norm_w;

   logic             vld_ff  [0:ITER];
   logic [30:0]      m_ff    [0:ITER];
   logic [FRAC_W-1:0] frac_ff [0:ITER];
   logic [3:0]       k_ff    [0:ITER];
   side_type         sd_ff   [0:ITER];

   logic [63:0]     fprod_w;
   logic            d_valid_ff;
   logic [31:0]     d_hi_ff;
   logic [LN_W-1:0] d_kl_ff;
   side_type        d_side_ff;

   logic            e_valid_ff;
   logic [LN_W-1:0] e_ln_ff;
   side_type        e_side_ff;

   assign sum_w  = {sample[31], sample} + {shift[31], shift};
   assign ovf_in = sum_w[32] ^ sum_w[31];
   assign t_in   = ovf_in ? (sum_w[32] ? NEG_MIN : POS_MAX) : sum_w[31:0];

   assign neg_w  = a_t_ff[31];
   assign tmag_w = neg_w ? (~a_t_ff + 32'd1) : a_t_ff;
   assign b_in   = tmag_w + ONE_Q16;
   assign l_w    = neg_w ? (LAMBDA_TWO_X - {a_power_ff[23], a_power_ff})
                         : {a_power_ff[23], a_power_ff};

   always_comb begin
      side_in.negative = neg_w;
      side_in.logpath  = neg_w ? (a_power_ff == LAMBDA_TWO) : (a_power_ff == 24'd0);
      side_in.ovf      = a_ovf_ff;
      side_in.l_neg    = l_w[24];
      side_in.lmag     = l_w[24] ? 24'(~l_w + 25'd1) : l_w[23:0];
   end

   always_comb begin
      msb_w = 5'd16;
      for (int i = 16; i < 32; i++) begin
         if (b_b_ff[i]) begin
            msb_w = 5'(i);
         end
      end
   end
   assign norm_w = b_b_ff << (5'd31 - msb_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         vld_ff[0]  <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         vld_ff[0]  <= b_valid_ff;
         d_valid_ff <= vld_ff[ITER];
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_t_ff     <= t_in;
         a_ovf_ff   <= ovf_in;
         a_power_ff <= power;
         b_b_ff     <= b_in;
         b_side_ff  <= side_in;
         m_ff[0]    <= norm_w[31:1];
         k_ff[0]    <= 4'(msb_w - 5'd16);
         frac_ff[0] <= '0;
         sd_ff[0]   <= b_side_ff;
      end
   end

   for (genvar j = 1; j <= ITER; j++) begin : g_sq
      logic [61:0] sq_w;
      logic [31:0] sh_w;

      assign sq_w = 62'(m_ff[j-1]) * 62'(m_ff[j-1]);
      assign sh_w = sq_w[61:30];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (advance) begin
            vld_ff[j] <= vld_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            m_ff[j]    <= sh_w[31] ? sh_w[31:1] : sh_w[30:0];
            frac_ff[j] <= frac_ff[j-1] | (sh_w[31] ? (FRAC_W'(1) << (FRAC_W - j)) : '0);
            k_ff[j]    <= k_ff[j-1];
            sd_ff[j]   <= sd_ff[j-1];
         end
      end
   end

   assign fprod_w = 64'(frac_ff[ITER][FRAC_W-1:16]) * 64'(LN2_Q32);

   always_ff @(posedge clock) begin
      if (advance) begin
         d_hi_ff   <= fprod_w[63:32];
         d_kl_ff   <= LN_W'(k_ff[ITER]) * LN_W'(LN2_Q32);
         d_side_ff <= sd_ff[ITER];
         e_ln_ff   <= d_kl_ff + LN_W'(d_hi_ff);
         e_side_ff <= d_side_ff;
      end
   end

   assign out_valid = e_valid_ff;
   assign ln        = e_ln_ff;
   assign side      = e_side_ff;

endmodule

[rtl/yjt_exp.sv]
module yjt_exp
   import yjt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            in_valid,
   input  logic [LN_W-1:0] ln,
   input  side_type        side,
   output logic            out_valid,
   output logic [63:0]     d,
   output path_type        path
);

   typedef struct packed {
      path_type         path;
      logic             zero;
      logic [EXP_Q_W-1:0] q;
      logic [RED_W-1:0] rem;
   } red_type;

   typedef struct packed {
      path_type           path;
      logic               zero;
      logic [EXP_Q_W-1:0] q;
      logic [31:0]        r;
      logic [32:0]        term;
      logic [33:0]        sum;
      logic [31:0]        v;
      logic [31:0]        qe;
   } ser_type;

   localparam int NSER = 3 * ITER;

   logic        p1_valid_ff;
   logic [41:0] p1_pa_ff;
   logic [17:0] p1_hi_ff;
   logic [19:0] p1_logmag_ff;
   side_type    p1_side_ff;

   logic [59:0]    p2_full_w;
   logic           p2_valid_ff;
   logic [P_W-1:0] p2_p_ff;
   logic [19:0]    p2_logmag_ff;
   side_type       p2_side_ff;

   red_type red_in;
   logic    red_vld_ff [0:EXP_Q_W];
   red_type red_ff     [0:EXP_Q_W];

   ser_type ser_in;
   logic    ser_vld_ff [0:NSER];
   ser_type ser_ff     [0:NSER];

   logic [63:0] e_w;
   logic [63:0] d_in;
   logic        f_valid_ff;
   logic [63:0] f_d_ff;
   path_type    f_path_ff;

   assign p2_full_w = 60'(p1_pa_ff) + ((60'(p1_side_ff.lmag) * 60'(p1_hi_ff)) << 18);

   always_comb begin
      logic sat_w;
      logic zero_w;
      sat_w  = !p2_side_ff.logpath && !p2_side_ff.l_neg && (p2_p_ff >= EXP_LIMIT);
      zero_w = !p2_side_ff.logpath && p2_side_ff.l_neg && (p2_p_ff > ZERO_LIMIT);
      red_in.path.side   = p2_side_ff;
      red_in.path.logmag = p2_logmag_ff;
      red_in.path.sat    = sat_w;
      red_in.zero        = zero_w;
      red_in.q           = '0;
      red_in.rem         = (sat_w || zero_w || p2_side_ff.logpath) ? '0 : p2_p_ff[RED_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff   <= 1'b0;
         p2_valid_ff   <= 1'b0;
         red_vld_ff[0] <= 1'b0;
      end else if (advance) begin
         p1_valid_ff   <= in_valid;
         p2_valid_ff   <= p1_valid_ff;
         red_vld_ff[0] <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_pa_ff     <= 42'(side.lmag) * 42'(ln[17:0]);
         p1_hi_ff     <= ln[35:18];
         p1_logmag_ff <= ln[35:16];
         p1_side_ff   <= side;
         p2_p_ff      <= p2_full_w[59:16];
         p2_logmag_ff <= p1_logmag_ff;
         p2_side_ff   <= p1_side_ff;
         red_ff[0]    <= red_in;
      end
   end

   for (genvar k = 1; k <= EXP_Q_W; k++) begin : g_red
      localparam int Bit = EXP_Q_W - k;
      localparam logic [RED_W-1:0] Step = RED_W'(LN2_Q32) << Bit;
      red_type nxt_w;

      always_comb begin
         nxt_w = red_ff[k-1];
         if (red_ff[k-1].rem >= Step) begin
            nxt_w.rem    = red_ff[k-1].rem - Step;
            nxt_w.q[Bit] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            red_vld_ff[k] <= 1'b0;
         end else if (advance) begin
            red_vld_ff[k] <= red_vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            red_ff[k] <= nxt_w;
         end
      end
   end

   always_comb begin
      red_type src;
      src            = red_ff[EXP_Q_W];
      ser_in.path    = src.path;
      ser_in.zero    = src.zero;
      ser_in.q       = src.q;
      ser_in.r       = src.rem[31:0];
      if (src.path.side.l_neg && (src.rem != '0)) begin
         ser_in.r = LN2_Q32 - src.rem[31:0];
         ser_in.q = src.q + EXP_Q_W'(1);
      end
      ser_in.term = ONE_Q32;
      ser_in.sum  = 34'(ONE_Q32);
      ser_in.v    = '0;
      ser_in.qe   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_vld_ff[0] <= 1'b0;
      end else if (advance) begin
         ser_vld_ff[0] <= red_vld_ff[EXP_Q_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ser_ff[0] <= ser_in;
      end
   end

   for (genvar i = 1; i <= ITER; i++) begin : g_ser
      localparam int Idx = i;
      localparam int Base = 3 * (i - 1);
      localparam logic [32:0] Recip = 33'((64'd1 << 32) / Idx);
      logic [64:0] mul_w;
      logic [64:0] rcp_w;
      logic [31:0] rm_w;
      logic [31:0] qc_w;
      ser_type     m_in;
      ser_type     r_in;
      ser_type     c_in;

      assign mul_w = 65'(ser_ff[Base].term) * 65'(ser_ff[Base].r);
      assign rcp_w = 65'(ser_ff[Base+1].v) * 65'(Recip);
      assign rm_w  = ser_ff[Base+2].v - 32'(ser_ff[Base+2].qe * 32'(Idx));
      assign qc_w  = (rm_w >= 32'(Idx)) ? ser_ff[Base+2].qe + 32'd1 : ser_ff[Base+2].qe;

      always_comb begin
         m_in      = ser_ff[Base];
         m_in.v    = mul_w[63:32];
         r_in      = ser_ff[Base+1];
         r_in.qe   = rcp_w[63:32];
         c_in      = ser_ff[Base+2];
         c_in.term = 33'(qc_w);
         c_in.sum  = ser_ff[Base+2].sum + 34'(qc_w);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ser_vld_ff[Base+1] <= 1'b0;
            ser_vld_ff[Base+2] <= 1'b0;
            ser_vld_ff[Base+3] <= 1'b0;
         end else if (advance) begin
            ser_vld_ff[Base+1] <= ser_vld_ff[Base];
            ser_vld_ff[Base+2] <= ser_vld_ff[Base+1];
            ser_vld_ff[Base+3] <= ser_vld_ff[Base+2];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            ser_ff[Base+1] <= m_in;
            ser_ff[Base+2] <= r_in;
            ser_ff[Base+3] <= c_in;
         end
      end
   end

   always_comb begin
      if (!ser_ff[NSER].path.side.l_neg) begin
         e_w = 64'(ser_ff[NSER].sum) << ser_ff[NSER].q;
      end else if (ser_ff[NSER].zero) begin
         e_w = '0;
      end else begin
         e_w = 64'(ser_ff[NSER].sum) >> ser_ff[NSER].q;
      end
      d_in = (e_w >= 64'(ONE_Q32)) ? e_w - 64'(ONE_Q32) : 64'(ONE_Q32) - e_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (advance) begin
         f_valid_ff <= ser_vld_ff[NSER];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f_d_ff    <= d_in;
         f_path_ff <= ser_ff[NSER].path;
      end
   end

   assign out_valid = f_valid_ff;
   assign d         = f_d_ff;
   assign path      = f_path_ff;

endmodule

[rtl/yjt_div.sv]
module yjt_div
   import yjt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         in_valid,
   input  logic [63:0]  d,
   input  path_type     path,
   output logic         out_valid,
   output logic [31:0]  transformed,
   output logic         overflow
);

   typedef struct packed {
      path_type           path;
      logic               big;
      logic [REM_W-1:0]   rem;
      logic [DIV_Q_W-1:0] quo;
   } dv_type;

   dv_type dv_in;
   logic   dv_vld_ff [0:DIV_Q_W];
   dv_type dv_ff     [0:DIV_Q_W];

   logic [DIV_Q_W-1:0] mag_w;
   logic               clamp_w;
   logic [31:0]        y_in;
   logic               out_valid_ff;
   logic [31:0]        y_ff;
   logic               ovf_ff;
   logic               neg_ff;

   always_comb begin
      logic ovq_w;
      ovq_w          = d >= {7'd0, path.side.lmag, 33'd0};
      dv_in.path     = path;
      dv_in.big      = path.sat || (ovq_w && !path.side.logpath);
      dv_in.rem      = ovq_w ? '0 : d[REM_W-1:0];
      dv_in.quo      = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (advance) begin
         dv_vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dv_ff[0] <= dv_in;
      end
   end

   for (genvar k = 1; k <= DIV_Q_W; k++) begin : g_div
      localparam int Bit = DIV_Q_W - k;
      logic [REM_W-1:0] dsr_w;
      dv_type           nxt_w;

      assign dsr_w = REM_W'(dv_ff[k-1].path.side.lmag) << Bit;

      always_comb begin
         nxt_w = dv_ff[k-1];
         if (dv_ff[k-1].rem >= dsr_w) begin
            nxt_w.rem      = dv_ff[k-1].rem - dsr_w;
            nxt_w.quo[Bit] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k] <= 1'b0;
         end else if (advance) begin
            dv_vld_ff[k] <= dv_vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            dv_ff[k] <= nxt_w;
         end
      end
   end

   always_comb begin
      dv_type s;
      s     = dv_ff[DIV_Q_W];
      mag_w = s.path.side.logpath ? DIV_Q_W'(s.path.logmag) : s.quo;
      if (!s.path.side.negative) begin
         clamp_w = s.big || (mag_w > DIV_Q_W'(POS_MAX));
         y_in    = clamp_w ? POS_MAX : mag_w[31:0];
      end else begin
         clamp_w = s.big || (mag_w > DIV_Q_W'(NEG_MIN));
         y_in    = clamp_w ? NEG_MIN : (~mag_w[31:0] + 32'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= dv_vld_ff[DIV_Q_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         y_ff   <= y_in;
         ovf_ff <= clamp_w || dv_ff[DIV_Q_W].path.side.ovf;
         neg_ff <= dv_ff[DIV_Q_W].path.side.negative;
      end
   end

   assign out_valid   = out_valid_ff;
   assign transformed = y_ff;
   assign overflow    = ovf_ff;

   a_reset_clears: assert property (@(posedge clock) reset |=> !out_valid_ff)
      else $error("Result valid set right after reset.");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(out_valid_ff) && $stable(y_ff) && $stable(ovf_ff))
      else $error("Result changed while the pipeline was held.");

   a_sign_follows_branch: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && y_ff[31]) |-> neg_ff)
      else $error("Negative result from the non-negative branch.");

   a_sat_flags: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !neg_ff && y_ff == POS_MAX && !$past(dv_ff[DIV_Q_W].path.side.logpath)
       && $past(advance) && $past(dv_ff[DIV_Q_W].big)) |-> ovf_ff)
      else $error("Saturated result without overflow flag.");

endmodule

[rtl/yeo_johnson_transform_unit.sv]
// Yeo-Johnson power transform on signed Q16.16 samples, one request per clock unless
// the pipeline is frozen. Each request carries the sample, the column's lambda1 (Q8.16)
// and lambda2 (Q16.16); each one yields exactly one result, in order. The pipeline is
// made of the squaring stages of the binary logarithm, three stages per exponential
// series term, a six step range reduction and a 33 step restoring divider, all fully
// pipelined, so a new request is taken every cycle unless frozen. While a result is
// waiting with rsp_stall high, the whole pipeline is frozen and req_stall is raised in
// the same cycle. rsp_overflow is set when the sum or the result saturated to the
// signed 32-bit range.
module yeo_johnson_transform_unit
   import yjt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_sample,
   input  logic signed [23:0] req_power,
   input  logic signed [31:0] req_shift,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_transformed,
   output logic               rsp_overflow
);

   logic            advance;
   logic            log_valid;
   logic [LN_W-1:0] log_ln;
   side_type        log_side;
   logic            exp_valid;
   logic [63:0]     exp_d;
   path_type        exp_path;
   logic [31:0]     div_y;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   yjt_log u_log (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .sample    (req_sample),
      .power     (req_power),
      .shift     (req_shift),
      .out_valid (log_valid),
      .ln        (log_ln),
      .side      (log_side)
   );

   yjt_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (log_valid),
      .ln        (log_ln),
      .side      (log_side),
      .out_valid (exp_valid),
      .d         (exp_d),
      .path      (exp_path)
   );

   yjt_div u_div (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (exp_valid),
      .d           (exp_d),
      .path        (exp_path),
      .out_valid   (rsp_valid),
      .transformed (div_y),
      .overflow    (rsp_overflow)
   );

   assign rsp_transformed = div_y;

endmodule
